FILE: hw/rtl/rbp_pkg.sv
// Shared types, constants and helpers for the range bit packer.
package rbp_pkg;

	localparam int WORD_W    = 64;
	localparam int NBITS_W   = 7;
	localparam int OFFSET_W  = 6;
	localparam int BITS_W    = 17;
	localparam int CAP_W     = 11;
	localparam int INDEX_W   = 10;

	localparam logic [BITS_W-1:0] BITS_SAT  = 17'h1FFFF;
	localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1024;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// One checked input item, as held in the input register.
	typedef struct packed {
		logic [WORD_W-1:0]  value;
		logic [NBITS_W-1:0] nbits;
		logic               in_range;
	} item_t;

	// Number of bits needed to hold v; zero when v is zero.
	function automatic logic [NBITS_W-1:0] bit_len(input logic [WORD_W-1:0] v);
		logic [NBITS_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (v[i]) begin
				n = NBITS_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

FILE: hw/rtl/rbp_front.sv
// Input stage: range check, packed width and the input register.
module rbp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rbp_pkg::WORD_W-1:0]   value,
	input  logic [rbp_pkg::WORD_W-1:0]   min_allowed,
	input  logic [rbp_pkg::WORD_W-1:0]   max_allowed,
	output logic                         item_valid,
	output rbp_pkg::item_t               item,
	input  logic                         item_take
);

	logic           s1_valid_q;
	rbp_pkg::item_t item_s1;
	rbp_pkg::item_t item_d;

	assign in_ready = !s1_valid_q || item_take;

	always_comb begin
		item_d.value    = value;
		item_d.nbits    = rbp_pkg::bit_len(max_allowed);
		item_d.in_range = (value >= min_allowed) && (value <= max_allowed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = s1_valid_q;
	assign item       = item_s1;

endmodule

FILE: hw/rtl/rbp_core.sv
// Packing state, capacity register, result register and output sequencing.
module rbp_core #(
	parameter int MAX_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbp_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                          item_valid,
	input  rbp_pkg::item_t                item,
	output logic                          item_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          word_valid,
	output logic [rbp_pkg::INDEX_W-1:0]   word_index,
	output logic [rbp_pkg::WORD_W-1:0]    word_data,
	output logic [1:0]                    status,
	output logic [rbp_pkg::BITS_W-1:0]    total_bits,
	output logic                          last
);

	localparam int POS_W  = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
	localparam int CAPN_W = $clog2(MAX_WORDS + 1);
	localparam int CMP_W  = ((CAPN_W > rbp_pkg::CAP_W) ? CAPN_W : rbp_pkg::CAP_W) + 1;
	localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(MAX_WORDS);

	// Packing state.
	logic [rbp_pkg::WORD_W-1:0]   acc_q;
	logic [POS_W-1:0]             pos_q;
	logic [rbp_pkg::OFFSET_W-1:0] offset_q;
	logic [rbp_pkg::BITS_W-1:0]   bits_q;
	logic [rbp_pkg::CAP_W-1:0]    capacity_q;

	// Result register: one or two results of the last processed item.
	logic                         pair_valid_q;
	logic                         two_q;
	logic                         sel_q;
	rbp_pkg::status_t             status_q;
	logic [POS_W-1:0]             idx0_q;
	logic [rbp_pkg::WORD_W-1:0]   data0_q;
	logic [rbp_pkg::WORD_W-1:0]   data1_q;
	logic [rbp_pkg::BITS_W-1:0]   total_q;

	logic                         pair_done;
	logic                         pair_free;
	logic [CMP_W-1:0]             cap_eff;
	logic [rbp_pkg::NBITS_W-1:0]  end_bit;
	logic [rbp_pkg::WORD_W-1:0]   acc_or;
	logic [rbp_pkg::WORD_W-1:0]   rest;
	logic [rbp_pkg::NBITS_W-1:0]  rest_shift;
	logic [rbp_pkg::BITS_W:0]     bits_sum;
	logic [rbp_pkg::BITS_W-1:0]   bits_next;
	logic                         fits;
	logic                         full;
	logic                         crossing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= rbp_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// A capacity of zero counts as one word; anything above the buffer size is clamped.
	always_comb begin
		cap_eff = CMP_W'(capacity_q);
		if (capacity_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > MAX_CAP) begin
			cap_eff = MAX_CAP;
		end
	end

	assign pair_done = pair_valid_q && out_ready && (!two_q || sel_q);
	assign pair_free = !pair_valid_q || pair_done;
	assign item_take = item_valid && pair_free;

	always_comb begin
		end_bit    = rbp_pkg::NBITS_W'(offset_q) + item.nbits;
		acc_or     = acc_q | (item.value << offset_q);
		rest_shift = rbp_pkg::NBITS_W'(rbp_pkg::WORD_W) - rbp_pkg::NBITS_W'(offset_q);
		// The remainder only exists when the value runs past the word end.
		rest       = (end_bit > rbp_pkg::NBITS_W'(rbp_pkg::WORD_W)) ?
			(item.value >> rest_shift) : '0;
		bits_sum   = (rbp_pkg::BITS_W + 1)'(bits_q) + (rbp_pkg::BITS_W + 1)'(item.nbits);
		bits_next  = bits_sum[rbp_pkg::BITS_W] ? rbp_pkg::BITS_SAT :
			bits_sum[rbp_pkg::BITS_W-1:0];
		fits       = end_bit < rbp_pkg::NBITS_W'(rbp_pkg::WORD_W);
		full       = CMP_W'(pos_q) >= (cap_eff - CMP_W'(1));
		crossing   = item.in_range && !fits && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pos_q    <= '0;
			offset_q <= '0;
			bits_q   <= '0;
		end else if (item_take && item.in_range && (fits || !full)) begin
			acc_q    <= fits ? acc_or : rest;
			offset_q <= end_bit[rbp_pkg::OFFSET_W-1:0];
			bits_q   <= bits_next;
			if (!fits) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
			two_q        <= 1'b0;
			sel_q        <= 1'b0;
		end else if (item_take) begin
			pair_valid_q <= 1'b1;
			two_q        <= crossing;
			sel_q        <= 1'b0;
		end else if (pair_done) begin
			pair_valid_q <= 1'b0;
			sel_q        <= 1'b0;
		end else if (pair_valid_q && out_ready) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			data1_q <= rest;
			if (!item.in_range) begin
				status_q <= rbp_pkg::STAT_RANGE;
				idx0_q   <= '0;
				data0_q  <= '0;
				total_q  <= bits_q;
			end else if (!fits && full) begin
				status_q <= rbp_pkg::STAT_FULL;
				idx0_q   <= '0;
				data0_q  <= '0;
				total_q  <= bits_q;
			end else begin
				status_q <= rbp_pkg::STAT_OK;
				idx0_q   <= pos_q;
				data0_q  <= acc_or;
				total_q  <= bits_next;
			end
		end
	end

	assign out_valid  = pair_valid_q;
	assign word_valid = status_q == rbp_pkg::STAT_OK;
	assign word_index = sel_q ? rbp_pkg::INDEX_W'(idx0_q + POS_W'(1)) :
		rbp_pkg::INDEX_W'(idx0_q);
	assign word_data  = sel_q ? data1_q : data0_q;
	assign status     = status_q;
	assign total_bits = total_q;
	assign last       = sel_q || !two_q;

	a_sel_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (two_q && pair_valid_q))
		else $error("second result selected without a two-result item");

	a_cross_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && crossing) |=> (pos_q == $past(pos_q) + POS_W'(1)))
		else $error("word crossing did not advance the word position");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && !item.in_range) |=>
		($stable(acc_q) && $stable(offset_q) && $stable(pos_q) && $stable(bits_q)))
		else $error("rejected item changed the packing state");

	a_bits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (bits_q >= $past(bits_q)))
		else $error("bit total decreased");

endmodule

FILE: hw/rtl/range_bit_packer_unit.sv
// Top level of the range bit packer: input stage and packing core.
// Throughput: one item per cycle unless the output stalls; an item that crosses a
// word boundary holds the result register for two output transfers, so the output
// port sets the pace then. Items pass the input register, then the result register.
// Reset clears the packing state and sets the capacity register to 1024 words.
module range_bit_packer_unit #(
	parameter int MAX_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbp_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rbp_pkg::WORD_W-1:0]    value,
	input  logic [rbp_pkg::WORD_W-1:0]    min_allowed,
	input  logic [rbp_pkg::WORD_W-1:0]    max_allowed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          word_valid,
	output logic [rbp_pkg::INDEX_W-1:0]   word_index,
	output logic [rbp_pkg::WORD_W-1:0]    word_data,
	output logic [1:0]                    status,
	output logic [rbp_pkg::BITS_W-1:0]    total_bits,
	output logic                          last
);

	logic           item_valid;
	logic           item_take;
	rbp_pkg::item_t item;

	rbp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.min_allowed (min_allowed),
		.max_allowed (max_allowed),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	rbp_core #(
		.MAX_WORDS (MAX_WORDS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_valid (word_valid),
		.word_index (word_index),
		.word_data  (word_data),
		.status     (status),
		.total_bits (total_bits),
		.last       (last)
	);

endmodule

FILE: dv/range_bit_packer_unit_tb.sv
// Self-checking testbench for range_bit_packer_unit: directed table, then random phases.
module range_bit_packer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PK_MAX_WORDS = 1024;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          PHASES       = 8;
	localparam int          PHASE_ITEMS  = 205;
	localparam int          DIR_ROWS     = 19;
	localparam logic [63:0] ALL1         = '1;

	// One word transfer on the result port.
	typedef struct packed {
		logic                        wv;
		logic [rbp_pkg::INDEX_W-1:0] idx;
		logic [rbp_pkg::WORD_W-1:0]  data;
		rbp_pkg::status_t            st;
		logic [rbp_pkg::BITS_W-1:0]  bits;
		logic                        fin;
	} word_rec_t;

	// A directed row either writes the capacity or offers one item.
	typedef struct packed {
		logic                       cfg;
		logic [rbp_pkg::CAP_W-1:0]  cap;
		logic [rbp_pkg::WORD_W-1:0] v;
		logic [rbp_pkg::WORD_W-1:0] lo;
		logic [rbp_pkg::WORD_W-1:0] hi;
		logic                       typed;
		rbp_pkg::status_t           st;
		logic                       wv;
		logic [rbp_pkg::WORD_W-1:0] data;
		logic [rbp_pkg::BITS_W-1:0] bits;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [rbp_pkg::CAP_W-1:0]    cfg_wdata;
	logic                         in_valid;
	logic                         in_ready;
	logic [rbp_pkg::WORD_W-1:0]   value;
	logic [rbp_pkg::WORD_W-1:0]   min_allowed;
	logic [rbp_pkg::WORD_W-1:0]   max_allowed;
	logic                         out_valid;
	logic                         out_ready;
	logic                         word_valid;
	logic [rbp_pkg::INDEX_W-1:0]  word_index;
	logic [rbp_pkg::WORD_W-1:0]   word_data;
	logic [1:0]                   status;
	logic [rbp_pkg::BITS_W-1:0]   total_bits;
	logic                         last;

	// Packing state as the block should hold it.
	logic [rbp_pkg::WORD_W-1:0]   pk_acc;
	logic [rbp_pkg::INDEX_W-1:0]  pk_pos;
	logic [rbp_pkg::OFFSET_W-1:0] pk_off;
	logic [rbp_pkg::BITS_W-1:0]   pk_bits;
	logic [rbp_pkg::CAP_W-1:0]    pk_cap;

	word_rec_t pending_words[$];

	int  errors;
	int  n_items, n_words, n_cross, n_range, n_full, n_cfg;
	bit  idle_on;
	bit  hold_req;

	dir_row_t dir_tab [DIR_ROWS] = '{
		// Zero width right after reset: empty word 0.
		'{1'b0, 11'd0, 64'd0, 64'd0, 64'd0, 1'b1, rbp_pkg::STAT_OK, 1'b1, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd5, 64'd6, 64'd10, 1'b1, rbp_pkg::STAT_RANGE, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd11, 64'd6, 64'd10, 1'b1, rbp_pkg::STAT_RANGE, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd1, 64'd1, 64'd1, 1'b1, rbp_pkg::STAT_OK, 1'b1, 64'd1, 17'd1},
		// 63 bits at offset 1 land exactly on the word end.
		'{1'b0, 11'd0, 64'h2AAA_AAAA_AAAA_AAAA, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF,
			1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd3, 64'd0, 64'd3, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, ALL1, 64'd0, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, ALL1, ALL1, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd0, 64'd0, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd0, 64'd1, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, ALL1, 64'd0, ALL1 - 64'd1,
			1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd0, ALL1, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, ALL1,
			1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		// A capacity of zero acts as one word, so every crossing is refused.
		'{1'b1, 11'd0, 64'd0, 64'd0, 64'd0, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, ALL1, 64'd0, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd0, 64'd0, 64'd0, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, 64'd1, 64'd0, 64'd1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b1, 11'd2047, 64'd0, 64'd0, 64'd0, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0},
		'{1'b0, 11'd0, ALL1, 64'd0, ALL1, 1'b0, rbp_pkg::STAT_OK, 1'b0, 64'd0, 17'd0}
	};

	range_bit_packer_unit #(
		.MAX_WORDS(PK_MAX_WORDS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.min_allowed(min_allowed),
		.max_allowed(max_allowed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_valid (word_valid),
		.word_index (word_index),
		.word_data  (word_data),
		.status     (status),
		.total_bits (total_bits),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("Timeout: transfers stopped before the run completed");
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Applies one item to the packing state and queues the words it should produce.
	function automatic void pack_predict(input logic [63:0] v, input logic [63:0] lo,
			input logic [63:0] hi);
		int                         width;
		int                         stop;
		int                         eff_cap;
		int                         b;
		logic [17:0]                sum;
		logic [rbp_pkg::BITS_W-1:0] new_bits;
		logic [63:0]                done_w;
		logic [63:0]                rest;
		width = 0;
		for (b = 63; b >= 0; b--) begin
			if (hi[b]) begin
				width = b + 1;
				break;
			end
		end
		eff_cap = (pk_cap == '0) ? 1 : (int'(pk_cap) > PK_MAX_WORDS) ? PK_MAX_WORDS
			: int'(pk_cap);
		n_items++;
		if (v < lo || v > hi) begin
			n_range++;
			pending_words.push_back('{1'b0, '0, '0, rbp_pkg::STAT_RANGE, pk_bits, 1'b1});
			return;
		end
		stop = int'(pk_off) + width;
		sum = {1'b0, pk_bits} + 18'(width);
		new_bits = (sum > {1'b0, rbp_pkg::BITS_SAT}) ? rbp_pkg::BITS_SAT
			: sum[rbp_pkg::BITS_W-1:0];
		if (stop < 64) begin
			pk_acc  = pk_acc | (v << pk_off);
			pk_off  = rbp_pkg::OFFSET_W'(stop);
			pk_bits = new_bits;
			pending_words.push_back('{1'b1, pk_pos, pk_acc, rbp_pkg::STAT_OK, pk_bits, 1'b1});
			return;
		end
		if (int'(pk_pos) >= eff_cap - 1) begin
			n_full++;
			pending_words.push_back('{1'b0, '0, '0, rbp_pkg::STAT_FULL, pk_bits, 1'b1});
			return;
		end
		n_cross++;
		done_w = pk_acc | (v << pk_off);
		rest = (stop > 64) ? (v >> (64 - int'(pk_off))) : '0;
		pk_bits = new_bits;
		pending_words.push_back('{1'b1, pk_pos, done_w, rbp_pkg::STAT_OK, pk_bits, 1'b0});
		pk_pos = pk_pos + rbp_pkg::INDEX_W'(1);
		pk_acc = rest;
		pk_off = rbp_pkg::OFFSET_W'(stop - 64);
		pending_words.push_back('{1'b1, pk_pos, pk_acc, rbp_pkg::STAT_OK, pk_bits, 1'b1});
	endfunction

	// Offers one item and, once it transfers, records what it should produce.
	task automatic offer_item(input logic [63:0] v, input logic [63:0] lo,
			input logic [63:0] hi, input logic typed, input word_rec_t typed_rec);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 17)) begin
				@(negedge clk);
				in_valid    <= 1'b0;
				value       <= rand64();
				min_allowed <= rand64();
				max_allowed <= rand64();
			end
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		value       <= v;
		min_allowed <= lo;
		max_allowed <= hi;
		do @(posedge clk); while (!in_ready);
		pack_predict(v, lo, hi);
		if (typed) begin
			void'(pending_words.pop_back());
			pending_words.push_back(typed_rec);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [rbp_pkg::CAP_W-1:0] cap);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		pk_cap = cap;
		n_cfg++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range items of random width; some broken ranges and some pure noise.
	task automatic make_item(output logic [63:0] v, output logic [63:0] lo,
			output logic [63:0] hi);
		int          kind;
		int          width;
		logic [63:0] mask;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			v  = rand64();
			lo = rand64();
			hi = rand64();
			return;
		end
		case ($urandom_range(0, 9))
			0:       width = 64;
			1:       width = 0;
			2:       width = 1;
			default: width = $urandom_range(0, 64);
		endcase
		mask = (width == 64) ? ALL1 : ((64'd1 << width) - 64'd1);
		hi = rand64() & mask;
		if (width > 0) begin
			hi[width-1] = 1'b1;
		end
		v = rand64() & mask;
		if (v > hi) begin
			v = v - hi - 64'd1;
		end
		lo = rand64() & v;
		case ($urandom_range(0, 7))
			0:       v = hi;
			1:       lo = v;
			2:       lo = '0;
			default: ;
		endcase
		if (kind < 18) begin
			if (hi != ALL1 && $urandom_range(0, 1) == 1) begin
				v = hi + 64'd1;
			end else if (v != ALL1) begin
				lo = v + 64'd1;
			end else begin
				v  = '0;
				lo = 64'd1;
			end
		end
	endtask

	always @(posedge clk) begin
		word_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				flag_mismatch("unexpected result word_data", word_data, '0);
			end else begin
				want = pending_words.pop_front();
				n_words++;
				if (word_valid !== want.wv)
					flag_mismatch("word_valid", 64'(word_valid), 64'(want.wv));
				if (word_index !== want.idx)
					flag_mismatch("word_index", 64'(word_index), 64'(want.idx));
				if (word_data !== want.data)
					flag_mismatch("word_data", word_data, want.data);
				if (status !== want.st)
					flag_mismatch("status", 64'(status), 64'(want.st));
				if (total_bits !== want.bits)
					flag_mismatch("total_bits", 64'(total_bits), 64'(want.bits));
				if (last !== want.fin)
					flag_mismatch("last", 64'(last), 64'(want.fin));
			end
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0]               v;
		logic [63:0]               lo;
		logic [63:0]               hi;
		logic [rbp_pkg::CAP_W-1:0] cap;
		word_rec_t                 typed_rec;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		value       = '0;
		min_allowed = '0;
		max_allowed = '0;
		errors      = 0;
		n_items     = 0;
		n_words     = 0;
		n_cross     = 0;
		n_range     = 0;
		n_full      = 0;
		n_cfg       = 0;
		idle_on     = 1'b1;
		hold_req    = 1'b0;
		pk_acc      = '0;
		pk_pos      = '0;
		pk_off      = '0;
		pk_bits     = '0;
		pk_cap      = rbp_pkg::CAP_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_tab[r].cfg) begin
				write_capacity(dir_tab[r].cap);
			end else begin
				typed_rec = '{dir_tab[r].wv, '0, dir_tab[r].data, dir_tab[r].st,
					dir_tab[r].bits, 1'b1};
				offer_item(dir_tab[r].v, dir_tab[r].lo, dir_tab[r].hi,
					dir_tab[r].typed, typed_rec);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// Some phases leave only a word or two of room so that refusals pile up.
			case (ph)
				0:       cap = 11'd2047;
				1:       cap = rbp_pkg::CAP_W'(pk_pos) + 11'd2;
				2:       cap = 11'd1024;
				3:       cap = rbp_pkg::CAP_W'($urandom_range(0, 2047));
				4:       cap = rbp_pkg::CAP_W'(pk_pos) + 11'd1;
				5:       cap = 11'd1500;
				6:       cap = 11'd0;
				default: cap = 11'd1024;
			endcase
			write_capacity(cap);
			if (ph == PHASES - 1) begin
				idle_on = 1'b0;
			end
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				make_item(v, lo, hi);
				offer_item(v, lo, hi, 1'b0, '0);
			end
		end
		drain_results();

		$display("Packed %0d items into %0d result words: %0d word crossings, %0d range rejects,",
			n_items, n_words, n_cross, n_range);
		$display("%0d buffer-full rejects over %0d capacity writes, with one %0d-cycle output stall.",
			n_full, n_cfg, HOLD_CYCLES);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
